// ===== sv/ucf_pkg.sv =====
// ucf_pkg: shared types, codes and character classing functions for the
// utf-8 character class filter; no dependencies
`default_nettype none

package ucf_pkg;

   localparam int CountWidth = 16;
   localparam int MaxBytes   = 6;

   typedef enum logic [2:0] {
      MODE_ALL         = 3'd0,
      MODE_SYMBOLS_OFF = 3'd1,
      MODE_HALF_DIGIT  = 3'd2,
      MODE_HALF_ALNUM  = 3'd3,
      MODE_NO_SYSTEM   = 3'd4
   } mode_type;

   typedef enum logic {
      REG_CLASS_MODE = 1'b0,
      REG_CHAR_LIMIT = 1'b1
   } reg_type;

   typedef enum logic [1:0] {
      START_NONE  = 2'd0,
      START_FIRST = 2'd1,
      START_LATER = 2'd2
   } start_type;

   typedef struct packed {
      logic [2:0]  class_mode;
      logic [15:0] char_limit;
   } cfg_type;

   typedef struct packed {
      logic all_ok;
      logic sys;
      logic hnum;
      logic fnum;
      logic halpha;
      logic falpha;
      logic hkana;
      logic fkana;
      logic kanji;
   } flags_type;

   // one character's worth of result words
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [2:0]               count;
      logic                     data;
      logic                     str_end;
      logic [15:0]              kept;
   } burst_type;

   function automatic logic [2:0] char_length(input logic [7:0] b);
      logic [2:0] n;
      if (b < 8'h80) n = 3'd1;
      else if (b <= 8'hBF) n = 3'd1;
      else if (b <= 8'hDF) n = 3'd2;
      else if (b <= 8'hEF) n = 3'd3;
      else if (b <= 8'hF7) n = 3'd4;
      else if (b <= 8'hFB) n = 3'd5;
      else n = 3'd6;
      return n;
   endfunction

   function automatic flags_type mode_flags(input logic [2:0] m);
      flags_type f;
      f = '1;
      case (mode_type'(m))
         MODE_SYMBOLS_OFF: begin
            f.all_ok = 1'b0;
            f.sys    = 1'b0;
         end
         MODE_HALF_DIGIT: begin
            f = '0;
            f.hnum = 1'b1;
         end
         MODE_HALF_ALNUM: begin
            f = '0;
            f.hnum   = 1'b1;
            f.halpha = 1'b1;
         end
         MODE_NO_SYSTEM: begin
            f.sys = 1'b0;
         end
         default: begin
            f = '1;
         end
      endcase
      return f;
   endfunction

   function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                   input logic [7:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic logic keep_char(input logic [MaxBytes-1:0][7:0] c,
                                      input logic [2:0] n, input flags_type f);
      logic keep;
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
      keep = f.all_ok;
      c0 = c[0];
      c1 = c[1];
      c2 = c[2];
      if (n == 3'd1 && c0 < 8'h80) begin
         if (f.hnum && in_rng(c0, 8'h30, 8'h39)) keep = 1'b1;
         if (f.halpha && (in_rng(c0, 8'h41, 8'h5A) || in_rng(c0, 8'h61, 8'h7A))) keep = 1'b1;
         if (!f.sys && (c0 == 8'h3C || c0 == 8'h3E || c0 == 8'h23 || c0 == 8'h27 ||
                        c0 == 8'h2A || c0 == 8'h2C || c0 == 8'h22)) keep = 1'b0;
      end else if (n == 3'd2 && in_rng(c0, 8'hC0, 8'hDF)) begin
         keep = f.all_ok;
      end else if (n == 3'd3) begin
         if (c0 == 8'hE2) begin
            if (in_rng(c1, 8'h80, 8'hB9) || in_rng(c1, 8'hFA, 8'hFB)) keep = 1'b0;
         end
         if (c0 == 8'hE3) begin
            if (f.fkana && in_rng(c1, 8'h81, 8'h83)) keep = 1'b1;
            if (c1 == 8'h80 && c2 >= 8'h83) keep = 1'b0;
            if (!f.sys && c1 == 8'h82 && in_rng(c2, 8'h94, 8'h96)) keep = 1'b0;
            if (in_rng(c1, 8'h84, 8'h8F)) keep = 1'b0;
         end
         if (f.kanji && in_rng(c0, 8'hE4, 8'hE9)) keep = 1'b1;
         if (c0 == 8'hEF) begin
            if (c1 == 8'hBC) begin
               if (f.fnum && in_rng(c2, 8'h90, 8'h99)) keep = 1'b1;
               if (f.falpha && in_rng(c2, 8'hA1, 8'hBA)) keep = 1'b1;
            end
            if (c1 == 8'hBD) begin
               if (f.falpha && in_rng(c2, 8'h81, 8'h9A)) keep = 1'b1;
               if (f.hkana && in_rng(c2, 8'hA6, 8'hBF)) keep = 1'b1;
            end
            if (c1 == 8'hBE) begin
               if (f.hkana && in_rng(c2, 8'h80, 8'h9F)) keep = 1'b1;
            end
         end
      end else begin
         // emoji
         if (n >= 3'd2 && c0 == 8'hF0 && c1 == 8'h9F) keep = 1'b0;
      end
      return keep;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ucf_channel_if.sv =====
// ucf_req_if and ucf_rsp_if: valid/ready channels of the filter
// no dependencies
`default_nettype none

interface ucf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       string_last;

   modport source (output valid, output in_byte, output string_last, input ready);
   modport sink (input valid, input in_byte, input string_last, output ready);
endinterface

interface ucf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        run_last;
   logic        string_end;
   logic [15:0] kept_count;

   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output string_end, output kept_count, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input run_last,
                 input string_end, input kept_count, output ready);
endinterface

`default_nettype wire

// ===== sv/ucf_csr.sv =====
// ucf_csr: apb register file holding the class mode and char_limit
// depends on ucf_pkg
`default_nettype none

module ucf_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [2:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output ucf_pkg::cfg_type     cfg
);

   logic [2:0]  class_mode_ff;
   logic [15:0] char_limit_ff;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_mode_ff <= ucf_pkg::MODE_ALL;
         char_limit_ff <= 16'hFFFF;
      end else if (wr_en) begin
         if (ucf_pkg::reg_type'(csr_paddr[2]) == ucf_pkg::REG_CLASS_MODE) begin
            class_mode_ff <= csr_pwdata[2:0];
         end else begin
            char_limit_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_comb begin
      unique case (ucf_pkg::reg_type'(csr_paddr[2]))
         ucf_pkg::REG_CLASS_MODE: csr_prdata = {29'd0, class_mode_ff};
         ucf_pkg::REG_CHAR_LIMIT: csr_prdata = {16'd0, char_limit_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   assign cfg.class_mode = class_mode_ff;
   assign cfg.char_limit = char_limit_ff;

endmodule

`default_nettype wire

// ===== sv/ucf_assembler.sv =====
// ucf_assembler: input register, character assembly, bom skip, classing
// and per-string state; hands a burst of result words per kept character
// or bare string end; depends on ucf_pkg and ucf_req_if
`default_nettype none

module ucf_assembler (
   input  wire logic               clock,
   input  wire logic               reset,
   ucf_req_if.sink                 req_ch,
   input  wire ucf_pkg::cfg_type   cfg,
   output logic                    burst_valid,
   input  wire logic               burst_ready,
   output ucf_pkg::burst_type      burst
);

   localparam logic [ucf_pkg::CountWidth-1:0] CountMax = '1;

   logic                                   in_valid_ff;
   logic [7:0]                             in_byte_ff;
   logic                                   in_last_ff;
   logic [ucf_pkg::MaxBytes-1:0][7:0]      seq_ff;
   logic [ucf_pkg::MaxBytes-1:0][7:0]      seq_in;
   logic [2:0]                             needed_ff;
   logic [2:0]                             needed_in;
   logic [2:0]                             have_ff;
   logic [2:0]                             have_in;
   logic [ucf_pkg::CountWidth-1:0]         kept_ff;
   logic [ucf_pkg::CountWidth-1:0]         kept_in;
   ucf_pkg::start_type                     sp_ff;
   ucf_pkg::start_type                     sp_in;
   logic                                   halted_ff;
   logic                                   halted_in;

   logic                                   advance;
   logic                                   lead;
   logic [2:0]                             pos;
   logic [2:0]                             needed;
   logic [2:0]                             have_nx;
   logic                                   limit_hit;
   logic                                   active;
   logic                                   complete;
   logic [ucf_pkg::MaxBytes-1:0][7:0]      cbytes;
   ucf_pkg::start_type                     sp_eff;
   logic                                   bom;
   logic                                   keep;
   logic [ucf_pkg::CountWidth-1:0]         kept_nx;
   logic                                   emit;

   assign advance = in_valid_ff && (!emit || burst_ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         in_byte_ff <= req_ch.in_byte;
         in_last_ff <= req_ch.string_last;
      end
   end

   always_comb begin
      lead      = (needed_ff == 3'd0);
      pos       = lead ? 3'd0 : have_ff;
      needed    = lead ? ucf_pkg::char_length(in_byte_ff) : needed_ff;
      have_nx   = pos + 3'd1;
      limit_hit = lead && (in_byte_ff != 8'h00) && (32'(kept_ff) >= 32'(cfg.char_limit));
      active    = !halted_ff && (in_byte_ff != 8'h00) && !limit_hit;
      complete  = active && (have_nx >= needed);
      for (int i = 0; i < ucf_pkg::MaxBytes; i++) begin
         cbytes[i] = (3'(i) == pos) ? in_byte_ff : seq_ff[i];
      end
      sp_eff = (lead && active && sp_ff == ucf_pkg::START_NONE) ? ucf_pkg::START_FIRST : sp_ff;
      bom = (sp_eff == ucf_pkg::START_FIRST) && (needed == 3'd3) && (cbytes[0] == 8'hEF) &&
            (cbytes[1] == 8'hBB) && (cbytes[2] == 8'hBF);
      keep = complete && !bom &&
             ucf_pkg::keep_char(cbytes, needed, ucf_pkg::mode_flags(cfg.class_mode));
      kept_nx = (keep && kept_ff != CountMax) ? kept_ff + 1'b1 : kept_ff;
      emit = keep || in_last_ff;
   end

   // burst record toward the serializer
   always_comb begin
      burst_valid   = in_valid_ff && emit;
      burst.str_end = in_last_ff;
      burst.kept    = 16'(kept_nx);
      if (keep) begin
         burst.bytes = cbytes;
         burst.count = needed;
         burst.data  = 1'b1;
      end else begin
         burst.bytes = '0;
         burst.count = 3'd1;
         burst.data  = 1'b0;
      end
   end

   always_comb begin
      seq_in    = seq_ff;
      needed_in = needed_ff;
      have_in   = have_ff;
      kept_in   = kept_ff;
      sp_in     = sp_ff;
      halted_in = halted_ff;
      if (in_last_ff) begin
         needed_in = 3'd0;
         have_in   = 3'd0;
         kept_in   = '0;
         sp_in     = ucf_pkg::START_NONE;
         halted_in = 1'b0;
      end else if (!halted_ff) begin
         if (in_byte_ff == 8'h00) begin
            halted_in = 1'b1;
            needed_in = 3'd0;
            have_in   = 3'd0;
         end else if (limit_hit) begin
            halted_in = 1'b1;
         end else if (complete) begin
            needed_in = 3'd0;
            have_in   = 3'd0;
            sp_in     = ucf_pkg::START_LATER;
            kept_in   = kept_nx;
         end else begin
            seq_in[pos] = in_byte_ff;
            needed_in   = needed;
            have_in     = have_nx;
            sp_in       = sp_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needed_ff <= 3'd0;
         have_ff   <= 3'd0;
         kept_ff   <= '0;
         sp_ff     <= ucf_pkg::START_NONE;
         halted_ff <= 1'b0;
      end else if (advance) begin
         needed_ff <= needed_in;
         have_ff   <= have_in;
         kept_ff   <= kept_in;
         sp_ff     <= sp_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         seq_ff <= seq_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ucf_serializer.sv =====
// ucf_serializer: result register that plays one burst out as words,
// one byte a cycle while the receiver is ready
// depends on ucf_pkg and ucf_rsp_if
`default_nettype none

module ucf_serializer (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                burst_valid,
   output logic                     burst_ready,
   input  wire ucf_pkg::burst_type  burst,
   ucf_rsp_if.source                rsp_ch
);

   logic               valid_ff;
   logic               valid_in;
   ucf_pkg::burst_type burst_ff;
   ucf_pkg::burst_type burst_in;
   logic [2:0]         rem_ff;
   logic [2:0]         rem_in;
   logic               take;
   logic               final_word;

   assign final_word  = (rem_ff == 3'd1);
   assign take        = valid_ff && rsp_ch.ready;
   assign burst_ready = !valid_ff || (take && final_word);

   always_comb begin
      valid_in = valid_ff;
      burst_in = burst_ff;
      rem_in   = rem_ff;
      if (burst_ready) begin
         valid_in = burst_valid;
         burst_in = burst;
         rem_in   = burst.count;
      end else if (take) begin
         burst_in.bytes = {8'h00, burst_ff.bytes[ucf_pkg::MaxBytes-1:1]};
         rem_in         = rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rem_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.out_byte   = burst_ff.bytes[0];
   assign rsp_ch.byte_valid = burst_ff.data;
   assign rsp_ch.run_last   = final_word;
   assign rsp_ch.string_end = burst_ff.str_end && final_word;
   assign rsp_ch.kept_count = burst_ff.kept;

endmodule

`default_nettype wire

// ===== sv/utf8_character_class_filter.sv =====
// an accepted byte passes the input register, then the result register, to its words
// throughput: one byte per cycle unless stalled; kept characters of n bytes leave as
// n words, back-to-back while ready, overlapped with collecting the next character
// reset: synchronous, clears all string state, class mode to 0, char_limit to 65535
// top level of the utf-8 character class filter
// depends on ucf_pkg, ucf_req_if, ucf_rsp_if, ucf_csr, ucf_assembler, ucf_serializer
`default_nettype none

module utf8_character_class_filter (
   input  wire logic         clock,
   input  wire logic         reset,
   ucf_req_if.sink           req_ch,
   ucf_rsp_if.source         rsp_ch,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   ucf_pkg::cfg_type   cfg;
   ucf_pkg::burst_type burst;
   logic               burst_valid;
   logic               burst_ready;

   ucf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ucf_assembler u_assembler (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .cfg         (cfg),
      .burst_valid (burst_valid),
      .burst_ready (burst_ready),
      .burst       (burst)
   );

   ucf_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .burst_valid (burst_valid),
      .burst_ready (burst_ready),
      .burst       (burst),
      .rsp_ch      (rsp_ch)
   );

   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.string_end |-> rsp_ch.run_last)
      else $error("string end word is not the last of its run");

   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.byte_valid |-> rsp_ch.string_end && rsp_ch.out_byte == 8'h00)
      else $error("bare end marker malformed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== dv/ucf_checker.sv =====
// ucf_checker: watches the byte and word channels and the csr port of the utf-8
// character class filter, predicts every word and compares it with the block
// depends on ucf_pkg and ucf_channel_if
module ucf_checker
   import ucf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ucf_req_if          req_ch,
   ucf_rsp_if          rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          words_pending,
   output int          bytes_seen,
   output int          strings_seen,
   output int          words_seen,
   output logic [7:0]  modes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        run_last;
      logic        string_end;
      logic [15:0] kept_count;
   } word_type;

   word_type                 expected_words [$];
   logic [2:0]               class_mode;
   logic [15:0]              char_limit;
   logic [MaxBytes-1:0][7:0] char_bytes;
   logic [2:0]               need_len;
   logic [2:0]               have_len;
   logic [15:0]              kept_chars;
   start_type                start_pos;
   logic                     halted;

   function automatic logic in_span(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
      return v >= lo && v <= hi;
   endfunction

   function automatic logic [2:0] byte_span(input logic [7:0] b);
      casez (b)
         8'b110?????: return 3'd2;
         8'b1110????: return 3'd3;
         8'b11110???: return 3'd4;
         8'b111110??: return 3'd5;
         8'b111111??: return 3'd6;
         default: return 3'd1;
      endcase
   endfunction

   function automatic logic char_wanted(input logic [MaxBytes-1:0][7:0] c,
                                        input logic [2:0] n, input logic [2:0] m);
      logic all_ok;
      logic sym_ok;
      logic alpha_ok;
      logic wide_ok;
      logic keep;
      all_ok   = 1'b1;
      sym_ok   = 1'b1;
      alpha_ok = 1'b1;
      wide_ok  = 1'b1;
      case (mode_type'(m))
         MODE_SYMBOLS_OFF: begin
            all_ok = 1'b0;
            sym_ok = 1'b0;
         end
         MODE_HALF_DIGIT: begin
            all_ok   = 1'b0;
            sym_ok   = 1'b0;
            alpha_ok = 1'b0;
            wide_ok  = 1'b0;
         end
         MODE_HALF_ALNUM: begin
            all_ok  = 1'b0;
            sym_ok  = 1'b0;
            wide_ok = 1'b0;
         end
         MODE_NO_SYSTEM: begin
            sym_ok = 1'b0;
         end
         default: begin
         end
      endcase
      keep = all_ok;
      if (n == 3'd1 && !c[0][7]) begin
         if (in_span(c[0], 8'h30, 8'h39)) keep = 1'b1;
         if (alpha_ok && (in_span(c[0], 8'h41, 8'h5A) || in_span(c[0], 8'h61, 8'h7A)))
            keep = 1'b1;
         if (!sym_ok && (c[0] == 8'h22 || c[0] == 8'h23 || c[0] == 8'h27 || c[0] == 8'h2A ||
                         c[0] == 8'h2C || c[0] == 8'h3C || c[0] == 8'h3E))
            keep = 1'b0;
      end else if (n == 3'd3) begin
         // general punctuation and arrows
         if (c[0] == 8'hE2 && (in_span(c[1], 8'h80, 8'hB9) || in_span(c[1], 8'hFA, 8'hFB)))
            keep = 1'b0;
         if (c[0] == 8'hE3) begin
            if (wide_ok && in_span(c[1], 8'h81, 8'h83)) keep = 1'b1;
            if (c[1] == 8'h80 && c[2] >= 8'h83) keep = 1'b0;
            if (!sym_ok && c[1] == 8'h82 && in_span(c[2], 8'h94, 8'h96)) keep = 1'b0;
            if (in_span(c[1], 8'h84, 8'h8F)) keep = 1'b0;
         end
         if (wide_ok && in_span(c[0], 8'hE4, 8'hE9)) keep = 1'b1;
         if (wide_ok && c[0] == 8'hEF) begin
            case (c[1])
               8'hBC: if (in_span(c[2], 8'h90, 8'h99) || in_span(c[2], 8'hA1, 8'hBA))
                  keep = 1'b1;
               8'hBD: if (in_span(c[2], 8'h81, 8'h9A) || in_span(c[2], 8'hA6, 8'hBF))
                  keep = 1'b1;
               8'hBE: if (in_span(c[2], 8'h80, 8'h9F)) keep = 1'b1;
               default: begin
               end
            endcase
         end
      end else if (n >= 3'd2 && c[0] == 8'hF0 && c[1] == 8'h9F) begin
         keep = 1'b0;
      end
      return keep;
   endfunction

   function automatic void restart_string();
      char_bytes = '0;
      need_len   = '0;
      have_len   = '0;
      kept_chars = '0;
      start_pos  = START_NONE;
      halted     = 1'b0;
   endfunction

   task automatic take_byte(input logic [7:0] b, input logic last);
      word_type burst [$];
      word_type w;
      logic     bom;
      bytes_seen++;
      modes_seen[class_mode] = 1'b1;
      if (!halted) begin
         if (b == 8'h00) begin
            halted   = 1'b1;
            need_len = '0;
            have_len = '0;
         end else if (need_len == 0) begin
            if (kept_chars >= char_limit) begin
               halted = 1'b1;
            end else begin
               need_len      = byte_span(b);
               char_bytes[0] = b;
               have_len      = 3'd1;
               if (start_pos == START_NONE) start_pos = START_FIRST;
            end
         end else begin
            char_bytes[have_len] = b;
            have_len++;
         end
         if (!halted && need_len != 0 && have_len >= need_len) begin
            // byte-order mark is only skipped as the first character
            bom = start_pos == START_FIRST && need_len == 3'd3 && char_bytes[0] == 8'hEF &&
                  char_bytes[1] == 8'hBB && char_bytes[2] == 8'hBF;
            start_pos = START_LATER;
            if (!bom && char_wanted(char_bytes, need_len, class_mode)) begin
               if (kept_chars != 16'hFFFF) kept_chars++;
               for (int i = 0; i < need_len; i++) begin
                  w            = '0;
                  w.out_byte   = char_bytes[i];
                  w.byte_valid = 1'b1;
                  w.kept_count = kept_chars;
                  burst        = {burst, w};
               end
            end
            need_len = '0;
            have_len = '0;
         end
      end
      if (last) begin
         if (burst.size() == 0) begin
            w            = '0;
            w.string_end = 1'b1;
            w.kept_count = kept_chars;
            burst        = {burst, w};
         end else begin
            burst[burst.size()-1].string_end = 1'b1;
         end
         strings_seen++;
         restart_string();
      end
      if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
      expected_words = {expected_words, burst};
   endtask

   task automatic check_word();
      word_type got;
      word_type want;
      got.out_byte   = rsp_ch.out_byte;
      got.byte_valid = rsp_ch.byte_valid;
      got.run_last   = rsp_ch.run_last;
      got.string_end = rsp_ch.string_end;
      got.kept_count = rsp_ch.kept_count;
      words_seen++;
      if (expected_words.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t unexpected word: byte %h valid %b run_last %b end %b kept %0d",
                     $time, got.out_byte, got.byte_valid, got.run_last, got.string_end,
                     got.kept_count);
      end else begin
         want = expected_words.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
               $display({"%0t mismatch: expected byte %h valid %b run_last %b end %b kept %0d,",
                         " got byte %h valid %b run_last %b end %b kept %0d"}, $time,
                        want.out_byte, want.byte_valid, want.run_last, want.string_end,
                        want.kept_count, got.out_byte, got.byte_valid, got.run_last,
                        got.string_end, got.kept_count);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_string();
         class_mode = MODE_ALL;
         char_limit = 16'hFFFF;
         expected_words.delete();
         fail_count   = 0;
         bytes_seen   = 0;
         strings_seen = 0;
         words_seen   = 0;
         modes_seen   = '0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_word();
         if (req_ch.valid && req_ch.ready) take_byte(req_ch.in_byte, req_ch.string_last);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_type'(csr_paddr[2]))
               REG_CLASS_MODE: class_mode = csr_pwdata[2:0];
               REG_CHAR_LIMIT: char_limit = csr_pwdata[15:0];
               default: begin
               end
            endcase
         end
      end
      words_pending = expected_words.size();
   end

endmodule

// ===== dv/testbench.sv =====
// testbench: drives utf-8 strings and csr settings into the character class
// filter under random idling on both channels; ucf_checker does the checking
// depends on ucf_pkg, ucf_channel_if, utf8_character_class_filter, ucf_checker
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ucf_pkg::*;

   typedef enum int {
      CH_DIGIT, CH_LETTER, CH_RESERVED, CH_ASCII, CH_TWO, CH_PUNCT, CH_KANA,
      CH_CJK_MARK, CH_BRACKET, CH_E3_BLOCK, CH_KANJI, CH_FULL, CH_THREE, CH_EMOJI,
      CH_LONG, CH_STRAY, CH_BOM
   } char_kind_type;

   localparam logic [2:0]      ModeSpare  = 3'd7;
   localparam int              HoldCycles = 150;
   localparam logic [6:0][7:0] Reserved   = {8'h22, 8'h23, 8'h27, 8'h2A, 8'h2C, 8'h3C, 8'h3E};

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          fail_count;
   int          words_pending;
   int          bytes_seen;
   int          strings_seen;
   int          words_seen;
   logic [7:0]  modes_seen;

   logic [7:0]  text [$];
   int          bytes_offered = 0;
   bit          req_steady = 1'b0;
   bit          rsp_steady = 1'b0;
   bit          hold_off = 1'b0;

   ucf_req_if req_ch ();
   ucf_rsp_if rsp_ch ();

   utf8_character_class_filter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ucf_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .fail_count    (fail_count),
      .words_pending (words_pending),
      .bytes_seen    (bytes_seen),
      .strings_seen  (strings_seen),
      .words_seen    (words_seen),
      .modes_seen    (modes_seen)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("status: fail");
      $finish;
   end

   function automatic int idle_len(input bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [7:0] tail_byte();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(1, 255));
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   function automatic void put(input logic [7:0] b);
      text = {text, b};
   endfunction

   function automatic void put_char(input char_kind_type k);
      logic [7:0] lead;
      case (k)
         CH_DIGIT: put(8'($urandom_range(8'h30, 8'h39)));
         CH_LETTER: begin
            if ($urandom_range(0, 1) == 0) put(8'($urandom_range(8'h41, 8'h5A)));
            else put(8'($urandom_range(8'h61, 8'h7A)));
         end
         CH_RESERVED: put(Reserved[$urandom_range(0, 6)]);
         CH_ASCII: put(8'($urandom_range(1, 8'h7F)));
         CH_TWO: begin
            put(8'($urandom_range(8'hC0, 8'hDF)));
            put(tail_byte());
         end
         CH_PUNCT: begin
            put(8'hE2);
            put(8'($urandom_range(8'h80, 8'hFF)));
            put(tail_byte());
         end
         CH_KANA: begin
            put(8'hE3);
            put(8'($urandom_range(8'h81, 8'h83)));
            put(tail_byte());
         end
         CH_CJK_MARK: begin
            put(8'hE3);
            put(8'h80);
            put(8'($urandom_range(8'h80, 8'h86)));
         end
         CH_BRACKET: begin
            put(8'hE3);
            put(8'h82);
            put(8'($urandom_range(8'h92, 8'h98)));
         end
         CH_E3_BLOCK: begin
            put(8'hE3);
            put(8'($urandom_range(8'h84, 8'h8F)));
            put(tail_byte());
         end
         CH_KANJI: begin
            put(8'($urandom_range(8'hE4, 8'hE9)));
            put(tail_byte());
            put(tail_byte());
         end
         CH_FULL: begin
            put(8'hEF);
            put(8'($urandom_range(8'hBC, 8'hBE)));
            put(8'($urandom_range(8'h80, 8'hBF)));
         end
         CH_THREE: begin
            put(8'($urandom_range(8'hE0, 8'hEF)));
            put(tail_byte());
            put(tail_byte());
         end
         CH_EMOJI: begin
            put(8'hF0);
            put(8'h9F);
            put(tail_byte());
            put(tail_byte());
         end
         CH_LONG: begin
            lead = 8'($urandom_range(8'hF0, 8'hFF));
            put(lead);
            repeat (lead >= 8'hFC ? 5 : lead >= 8'hF8 ? 4 : 3) put(tail_byte());
         end
         CH_STRAY: put(8'($urandom_range(8'h80, 8'hBF)));
         default: begin
            put(8'hEF);
            put(8'hBB);
            put(8'hBF);
         end
      endcase
   endfunction

   // mostly well-formed text, some with a nul, a cut-off tail or pure noise
   function automatic void build_string();
      int         shape;
      logic [7:0] lead;
      shape = $urandom_range(0, 19);
      if ($urandom_range(0, 5) == 0) put_char(CH_BOM);
      repeat ($urandom_range(1, 5)) put_char(char_kind_type'($urandom_range(0, CH_BOM)));
      if (shape == 0) begin
         text[$urandom_range(0, text.size() - 1)] = 8'h00;
      end else if (shape < 3) begin
         lead = 8'($urandom_range(8'hC0, 8'hEF));
         put(lead);
         if (lead >= 8'hE0 && $urandom_range(0, 1) == 1) put(tail_byte());
      end else if (shape == 3) begin
         text.delete();
         repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = idle_len(req_steady);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.in_byte     <= b;
      req_ch.string_last <= last;
      bytes_offered++;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   task automatic send_text();
      for (int i = 0; i < text.size(); i++) push_byte(text[i], i == text.size() - 1);
      text.delete();
   endtask

   task automatic send_hex(input logic [63:0] s, input int n);
      for (int i = n - 1; i >= 0; i--) put(s[i*8 +: 8]);
      send_text();
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input reg_type r, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd1;
         2, 3: return 16'($urandom_range(2, 4));
         default: return 16'hFFFF;
      endcase
   endfunction

   // word receiver, with one long hold-off on request
   initial begin
      int span;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            span = idle_len(rsp_steady);
            if (span > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (span) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   initial begin
      int         phase;
      logic [2:0] mode;
      logic [15:0] limit;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.in_byte     = 8'h00;
      req_ch.string_last = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: bom skip, lone nul, six-byte lead, nul mid-string, cut-off char
      send_hex(64'hEFBBBF41, 4);
      send_hex(64'h00, 1);
      send_hex(64'hFF80BF818283, 6);
      send_hex(64'h310041, 3);
      send_hex(64'hE4B8, 2);
      settle();
      csr_write(REG_CLASS_MODE, 32'(MODE_NO_SYSTEM));
      csr_write(REG_CHAR_LIMIT, 32'd1);
      send_hex(64'h3C3031, 3);
      settle();
      csr_write(REG_CLASS_MODE, 32'(MODE_SYMBOLS_OFF));
      csr_write(REG_CHAR_LIMIT, 32'd0);
      send_hex(64'h41, 1);
      settle();
      csr_write(REG_CLASS_MODE, 32'(MODE_HALF_ALNUM));
      csr_write(REG_CHAR_LIMIT, 32'hFFFF);
      send_hex(64'hE3818261, 4);
      settle();
      csr_write(REG_CLASS_MODE, 32'(ModeSpare));
      send_hex(64'h22, 1);

      phase = 0;
      while (bytes_offered < 100) begin
         settle();
         mode  = phase < 8 ? 3'(phase) : 3'($urandom_range(0, 7));
         limit = phase == 0 ? 16'hFFFF : pick_limit();
         csr_write(REG_CLASS_MODE, ($urandom() & ~32'h7) | 32'(mode));
         csr_write(REG_CHAR_LIMIT, {16'($urandom()), limit});
         rsp_steady = $urandom_range(0, 3) == 0;
         if (phase == 0) begin
            hold_off   = 1'b1;
            req_steady = 1'b1;
            repeat (16) put_char(char_kind_type'($urandom_range(CH_DIGIT, CH_LETTER)));
            send_text();
         end
         repeat ($urandom_range(1, 3)) begin
            req_steady = $urandom_range(0, 3) == 0;
            build_string();
            send_text();
         end
         phase++;
      end
      settle();

      $display("run covered %0d bytes in %0d strings and %0d checked words", bytes_seen,
               strings_seen, words_seen);
      $display("%0d random settings phases, text modes exercised %b", phase, modes_seen);
      if (fail_count == 0 && words_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== utf8_character_class_filter.f =====
sv/ucf_pkg.sv
sv/ucf_channel_if.sv
sv/ucf_csr.sv
sv/ucf_assembler.sv
sv/ucf_serializer.sv
sv/utf8_character_class_filter.sv
dv/ucf_checker.sv
dv/testbench.sv
